FILE: rtl/core/lfu_cache_lru_tiebreak_assert.svh
// assertion macros for the lfu cache rtl
// needs nothing else; included by the modules that check their own logic
`ifndef LFU_CACHE_LRU_TIEBREAK_ASSERT_SVH
`define LFU_CACHE_LRU_TIEBREAK_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define LFU_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("lfu check failed");

// next-cycle implication, disabled while reset is asserted
`define LFU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("lfu check failed");

`endif

FILE: rtl/core/lfu_pkg.sv
`timescale 1ns / 1ps
// shared constants, types and helper functions of the lfu cache
// no dependencies
package lfu_pkg;

	localparam int ENTRIES    = 16;
	localparam int KEY_BITS   = 32;
	localparam int COUNT_BITS = 16;
	localparam int DATA_W     = 32;
	localparam int CFG_W      = 5;
	localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int OCC_W      = $clog2(ENTRIES + 1);

	localparam logic [CFG_W-1:0]      CAP_RESET  = CFG_W'(16);
	localparam logic [COUNT_BITS-1:0] COUNT_MAX  = '1;
	localparam logic [COUNT_BITS-1:0] COUNT_ONE  = COUNT_BITS'(1);
	localparam logic [DATA_W-1:0]     MISS_VALUE = '1;

	typedef logic [IDX_W-1:0]      idx_t;
	typedef logic [KEY_BITS-1:0]   key_t;
	typedef logic [DATA_W-1:0]     data_t;
	typedef logic [COUNT_BITS-1:0] count_t;
	typedef logic [OCC_W-1:0]      occ_t;

	typedef enum logic [1:0] {
		CMT_NONE   = 2'd0,
		CMT_TOUCH  = 2'd1,
		CMT_INSERT = 2'd2
	} cmt_op_t;

	// one entry as seen on the scan read port
	typedef struct packed {
		logic   valid;
		key_t   key;
		data_t  data;
		count_t count;
		idx_t   rank;
	} entry_t;

	// what a full scan leaves behind
	typedef struct packed {
		logic   found;
		idx_t   found_idx;
		data_t  found_data;
		count_t found_count;
		idx_t   found_rank;
		logic   vic_ok;
		idx_t   vic_idx;
		count_t vic_count;
		idx_t   vic_rank;
		key_t   vic_key;
		logic   free_ok;
		idx_t   free_idx;
	} scan_res_t;

	// one update of the entry store
	typedef struct packed {
		cmt_op_t op;
		idx_t    slot;
		idx_t    rank;
		logic    write_data;
		data_t   data;
		key_t    key;
		count_t  count;
		logic    evict;
		idx_t    vic_idx;
		idx_t    vic_rank;
	} commit_t;

	// sign-extend the 32-bit request key, keep the stored key width
	function automatic key_t to_key(input logic [31:0] k);
		logic [63:0] ext;
		ext = {{32{k[31]}}, k};
		return ext[KEY_BITS-1:0];
	endfunction

	// low 32 bits of a stored key
	function automatic logic [31:0] key_low32(input key_t k);
		logic [63:0] ext;
		ext = 64'(k);
		return ext[31:0];
	endfunction

endpackage

FILE: rtl/core/lfu_ifs.sv
`timescale 1ns / 1ps
// valid/ready channel interfaces for requests and responses
// no dependencies
interface lfu_req_if;
	logic               valid;
	logic               ready;
	logic               req_type;
	logic signed [31:0] lookup_key;
	logic signed [31:0] write_value;

	modport source (output valid, req_type, lookup_key, write_value, input ready);
	modport sink (input valid, req_type, lookup_key, write_value, output ready);
endinterface

interface lfu_rsp_if;
	logic               valid;
	logic               ready;
	logic               hit;
	logic signed [31:0] read_value;
	logic               evicted;
	logic signed [31:0] evicted_key;

	modport source (output valid, hit, read_value, evicted, evicted_key, input ready);
	modport sink (input valid, hit, read_value, evicted, evicted_key, output ready);
endinterface

FILE: rtl/core/lfu_cache_lru_tiebreak.sv
`timescale 1ns / 1ps
// top level of the lfu cache: sequencer, capacity register, result and
// output registers; uses lfu_pkg, lfu_ifs, lfu_scan, lfu_store
//
//  channel   dir  handshake     payload
//  req       in   valid/ready   req_type, lookup_key, write_value
//  rsp       out  valid/ready   hit, read_value, evicted, evicted_key
//  cfg       in   cfg_we        cfg_wdata (capacity_in_use)
//
// a response becomes valid once the request has passed the scan states,
// which step through the entries one at a time in the shared compare unit,
// the commit state, which loads the result register, and the emit state, which
// loads the output register; a request holds the block until its emit ends.
// req.ready is high only when idle; a stalled response holds the output
// register while the next request runs and waits in its last state.
// reset clears valid bits, occupancy and control; no clearing pass is needed.
`include "lfu_cache_lru_tiebreak_assert.svh"

module lfu_cache_lru_tiebreak (
	input  logic                        clk,
	input  logic                        arst_n,
	lfu_req_if.sink                     req,
	lfu_rsp_if.source                   rsp,
	input  logic                        cfg_we,
	input  logic [lfu_pkg::CFG_W-1:0]   cfg_wdata
);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SCAN   = 4'b0010,
		ST_COMMIT = 4'b0100,
		ST_EMIT   = 4'b1000
	} state_t;

	state_t                    state_q;
	lfu_pkg::idx_t             idx_q;
	logic [lfu_pkg::CFG_W-1:0] cap_q;
	lfu_pkg::occ_t             occ_q;
	logic                      put_q;
	lfu_pkg::key_t             key_q;
	lfu_pkg::data_t            wdata_q;

	logic                      res_hit_q;
	lfu_pkg::data_t            res_rd_q;
	logic                      res_ev_q;
	logic [31:0]               res_evk_q;

	logic                      out_valid_q;
	logic                      out_hit_q;
	lfu_pkg::data_t            out_rd_q;
	logic                      out_ev_q;
	logic [31:0]               out_evk_q;

	logic                      req_acc;
	logic                      scan_step;
	logic                      last_idx;
	logic                      emit_go;
	lfu_pkg::occ_t             cap_eff;
	lfu_pkg::entry_t           rd_ent;
	lfu_pkg::scan_res_t        scan_res;
	lfu_pkg::commit_t          cmt;
	logic                      c_hit;
	lfu_pkg::data_t            c_rd;
	logic                      c_ev;
	logic                      need_evict;

	assign req.ready = (state_q == ST_IDLE);
	assign req_acc   = req.valid && req.ready;
	assign scan_step = (state_q == ST_SCAN);
	assign last_idx  = (idx_q == lfu_pkg::IDX_W'(lfu_pkg::ENTRIES - 1));
	assign emit_go   = (state_q == ST_EMIT) && (!out_valid_q || rsp.ready);

	always_comb begin
		if (32'(cap_q) > lfu_pkg::ENTRIES) begin
			cap_eff = lfu_pkg::OCC_W'(lfu_pkg::ENTRIES);
		end else begin
			cap_eff = lfu_pkg::OCC_W'(cap_q);
		end
	end

	lfu_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_idx (idx_q),
		.rd_ent (rd_ent),
		.cmt    (cmt)
	);

	lfu_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (req_acc),
		.step   (scan_step),
		.idx    (idx_q),
		.ent    (rd_ent),
		.key    (key_q),
		.res    (scan_res)
	);

	// decide the store update and the response from the finished scan
	always_comb begin
		cmt            = '0;
		cmt.op         = lfu_pkg::CMT_NONE;
		cmt.key        = key_q;
		cmt.data       = wdata_q;
		cmt.write_data = put_q;
		c_hit          = 1'b0;
		c_rd           = '0;
		c_ev           = 1'b0;
		need_evict     = (occ_q >= cap_eff) && scan_res.vic_ok;
		if (state_q == ST_COMMIT) begin
			priority if (scan_res.found) begin
				c_hit     = 1'b1;
				c_rd      = put_q ? '0 : scan_res.found_data;
				cmt.op    = lfu_pkg::CMT_TOUCH;
				cmt.slot  = scan_res.found_idx;
				cmt.rank  = scan_res.found_rank;
				cmt.count = (scan_res.found_count == lfu_pkg::COUNT_MAX) ?
					scan_res.found_count : scan_res.found_count + 1'b1;
			end else if (!put_q) begin
				c_rd = lfu_pkg::MISS_VALUE;
			end else if (cap_eff != '0) begin
				cmt.count    = lfu_pkg::COUNT_ONE;
				cmt.vic_idx  = scan_res.vic_idx;
				cmt.vic_rank = scan_res.vic_rank;
				if (need_evict) begin
					// the freed victim slot counts as free for the lowest-slot choice
					c_ev      = 1'b1;
					cmt.evict = 1'b1;
					cmt.op    = lfu_pkg::CMT_INSERT;
					cmt.slot  = (scan_res.free_ok && (scan_res.free_idx < scan_res.vic_idx)) ?
						scan_res.free_idx : scan_res.vic_idx;
				end else if (scan_res.free_ok) begin
					cmt.op   = lfu_pkg::CMT_INSERT;
					cmt.slot = scan_res.free_idx;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			cap_q       <= lfu_pkg::CAP_RESET;
			occ_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			// a new beat may replace the one taken in the same cycle
			if (emit_go) begin
				out_valid_q <= 1'b1;
			end else if (rsp.valid && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			if ((cmt.op == lfu_pkg::CMT_INSERT) && !cmt.evict) begin
				occ_q <= occ_q + 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
					if (req_acc) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (last_idx) begin
						state_q <= ST_COMMIT;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_COMMIT: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (emit_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			put_q   <= req.req_type;
			key_q   <= lfu_pkg::to_key(req.lookup_key);
			wdata_q <= req.write_value;
		end
		if (state_q == ST_COMMIT) begin
			res_hit_q <= c_hit;
			res_rd_q  <= c_rd;
			res_ev_q  <= c_ev;
			res_evk_q <= c_ev ? lfu_pkg::key_low32(scan_res.vic_key) : '0;
		end
		if (emit_go) begin
			out_hit_q <= res_hit_q;
			out_rd_q  <= res_rd_q;
			out_ev_q  <= res_ev_q;
			out_evk_q <= res_evk_q;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.hit         = out_hit_q;
	assign rsp.read_value  = out_rd_q;
	assign rsp.evicted     = out_ev_q;
	assign rsp.evicted_key = out_evk_q;

	`LFU_ASSERT_NEXT(a_accept_scans, clk, arst_n, req_acc, state_q == ST_SCAN)
	`LFU_ASSERT_NEXT(a_commit_emits, clk, arst_n, state_q == ST_COMMIT, state_q == ST_EMIT)
	`LFU_ASSERT_NEXT(a_emit_loads, clk, arst_n, emit_go, rsp.valid && (state_q == ST_IDLE))
	`LFU_ASSERT_NOW(a_evict_no_hit, clk, arst_n, rsp.valid && rsp.evicted, !rsp.hit)
	`LFU_ASSERT_NOW(a_occ_bound, clk, arst_n, 1'b1, 32'(occ_q) <= lfu_pkg::ENTRIES)

endmodule

FILE: rtl/core/lfu_scan.sv
`timescale 1ns / 1ps
// shared compare unit: looks at one entry per cycle for key match,
// eviction victim and first free slot; uses lfu_pkg
module lfu_scan (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               step,
	input  lfu_pkg::idx_t      idx,
	input  lfu_pkg::entry_t    ent,
	input  lfu_pkg::key_t      key,
	output lfu_pkg::scan_res_t res
);

	lfu_pkg::scan_res_t res_q;
	logic match;
	logic better;
	logic take_match;
	logic take_vic;
	logic take_free;

	assign match  = ent.valid && (ent.key == key);
	// lower count wins, on equal count the older (higher rank) entry wins
	assign better = !res_q.vic_ok || (ent.count < res_q.vic_count) ||
		((ent.count == res_q.vic_count) && (ent.rank > res_q.vic_rank));

	assign take_match = step && match && !res_q.found;
	assign take_vic   = step && ent.valid && better;
	assign take_free  = step && !ent.valid && !res_q.free_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= '0;
		end else if (start) begin
			res_q.found   <= 1'b0;
			res_q.vic_ok  <= 1'b0;
			res_q.free_ok <= 1'b0;
		end else begin
			if (take_match) begin
				res_q.found       <= 1'b1;
				res_q.found_idx   <= idx;
				res_q.found_data  <= ent.data;
				res_q.found_count <= ent.count;
				res_q.found_rank  <= ent.rank;
			end
			if (take_vic) begin
				res_q.vic_ok    <= 1'b1;
				res_q.vic_idx   <= idx;
				res_q.vic_count <= ent.count;
				res_q.vic_rank  <= ent.rank;
				res_q.vic_key   <= ent.key;
			end
			if (take_free) begin
				res_q.free_ok  <= 1'b1;
				res_q.free_idx <= idx;
			end
		end
	end

	assign res = res_q;

endmodule

FILE: rtl/core/lfu_store.sv
`timescale 1ns / 1ps
// entry store: keys, values, use counts, recency ranks and valid bits,
// one scan read port and one commit per request; uses lfu_pkg
module lfu_store (
	input  logic             clk,
	input  logic             arst_n,
	input  lfu_pkg::idx_t    rd_idx,
	output lfu_pkg::entry_t  rd_ent,
	input  lfu_pkg::commit_t cmt
);

	logic            valid_q [lfu_pkg::ENTRIES];
	lfu_pkg::key_t   key_q   [lfu_pkg::ENTRIES];
	lfu_pkg::data_t  data_q  [lfu_pkg::ENTRIES];
	lfu_pkg::count_t count_q [lfu_pkg::ENTRIES];
	lfu_pkg::idx_t   rank_q  [lfu_pkg::ENTRIES];

	assign rd_ent.valid = valid_q[rd_idx];
	assign rd_ent.key   = key_q[rd_idx];
	assign rd_ent.data  = data_q[rd_idx];
	assign rd_ent.count = count_q[rd_idx];
	assign rd_ent.rank  = rank_q[rd_idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < lfu_pkg::ENTRIES; i++) begin
				valid_q[i] <= 1'b0;
			end
		end else if (cmt.op == lfu_pkg::CMT_INSERT) begin
			// a victim slot that takes the new entry simply stays valid
			if (cmt.evict && (cmt.vic_idx != cmt.slot)) begin
				valid_q[cmt.vic_idx] <= 1'b0;
			end
			valid_q[cmt.slot] <= 1'b1;
		end
	end

	// rank moves are independent per entry
	always_ff @(posedge clk) begin
		for (int i = 0; i < lfu_pkg::ENTRIES; i++) begin
			unique case (cmt.op)
				lfu_pkg::CMT_TOUCH: begin
					if (lfu_pkg::IDX_W'(i) == cmt.slot) begin
						rank_q[i] <= '0;
					end else if (valid_q[i] && (rank_q[i] < cmt.rank)) begin
						rank_q[i] <= rank_q[i] + 1'b1;
					end
				end
				lfu_pkg::CMT_INSERT: begin
					// entries older than the victim close the gap and age by one: net zero
					if (lfu_pkg::IDX_W'(i) == cmt.slot) begin
						rank_q[i] <= '0;
					end else if (valid_q[i] && !(cmt.evict &&
						((lfu_pkg::IDX_W'(i) == cmt.vic_idx) || (rank_q[i] > cmt.vic_rank)))) begin
						rank_q[i] <= rank_q[i] + 1'b1;
					end
				end
				lfu_pkg::CMT_NONE: begin
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmt.op)
			lfu_pkg::CMT_TOUCH: begin
				count_q[cmt.slot] <= cmt.count;
				if (cmt.write_data) begin
					data_q[cmt.slot] <= cmt.data;
				end
			end
			lfu_pkg::CMT_INSERT: begin
				key_q[cmt.slot]   <= cmt.key;
				data_q[cmt.slot]  <= cmt.data;
				count_q[cmt.slot] <= cmt.count;
			end
			lfu_pkg::CMT_NONE: begin
			end
			default: begin
			end
		endcase
	end

endmodule

FILE: bench/lfu_cache_lru_tiebreak_test.sv
`timescale 1ns / 1ps
// self-checking bench for the lfu cache with lru tie-break: drives requests,
// predicts each reply from a shadow copy of the cache and compares beat by beat
// depends on lfu_pkg, lfu_ifs and lfu_cache_lru_tiebreak
module lfu_cache_lru_tiebreak_test;

	localparam int STALL_LIMIT = 2000;
	localparam int REPORT_MAX  = 10;

	typedef struct {
		logic           hit;
		lfu_pkg::data_t read_value;
		logic           evicted;
		logic [31:0]    evicted_key;
	} reply_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [lfu_pkg::CFG_W-1:0] cfg_wdata;

	lfu_req_if req_ch ();
	lfu_rsp_if rsp_ch ();

	lfu_cache_lru_tiebreak dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_ch),
		.rsp      (rsp_ch),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// shadow copy of the cache
	logic                      cache_valid [lfu_pkg::ENTRIES];
	lfu_pkg::key_t             cache_key   [lfu_pkg::ENTRIES];
	lfu_pkg::data_t            cache_data  [lfu_pkg::ENTRIES];
	lfu_pkg::count_t           cache_count [lfu_pkg::ENTRIES];
	lfu_pkg::idx_t             cache_rank  [lfu_pkg::ENTRIES];
	int                        cache_occ;
	logic [lfu_pkg::CFG_W-1:0] cache_cap;

	reply_t        replies_due [$];
	lfu_pkg::key_t key_pool [$];

	int  bad_beats;
	int  requests_sent;
	int  hits_seen;
	int  evictions_seen;
	int  cap_writes;
	int  hold_left;
	bit  send_gaps;
	bit  recv_stalls;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// reply for one request, updating the shadow cache
	function automatic reply_t lfu_apply(input logic is_put, input lfu_pkg::key_t k,
		input lfu_pkg::data_t v);
		reply_t        r;
		int            found;
		int            victim;
		int            slot;
		int            eff_cap;
		lfu_pkg::idx_t old_rank;
		r = '{hit: 1'b0, read_value: '0, evicted: 1'b0, evicted_key: '0};
		eff_cap = (cache_cap > lfu_pkg::ENTRIES) ? lfu_pkg::ENTRIES : int'(cache_cap);
		found = -1;
		for (int i = 0; i < lfu_pkg::ENTRIES; i++)
			if (found < 0 && cache_valid[i] && cache_key[i] == k)
				found = i;
		if (found >= 0) begin
			r.hit = 1'b1;
			if (is_put)
				cache_data[found] = v;
			else
				r.read_value = cache_data[found];
			if (cache_count[found] != lfu_pkg::COUNT_MAX)
				cache_count[found]++;
			// move to front, entries ahead of it slide back one rank
			old_rank = cache_rank[found];
			for (int i = 0; i < lfu_pkg::ENTRIES; i++)
				if (cache_valid[i] && cache_rank[i] < old_rank)
					cache_rank[i]++;
			cache_rank[found] = '0;
		end else if (!is_put) begin
			r.read_value = lfu_pkg::MISS_VALUE;
		end else if (eff_cap > 0) begin
			if (cache_occ >= eff_cap) begin
				// lowest count first, then least recent
				victim = -1;
				for (int i = 0; i < lfu_pkg::ENTRIES; i++) begin
					if (!cache_valid[i])
						continue;
					if (victim < 0 || cache_count[i] < cache_count[victim] ||
					    (cache_count[i] == cache_count[victim] &&
					     cache_rank[i] > cache_rank[victim]))
						victim = i;
				end
				if (victim >= 0) begin
					old_rank = cache_rank[victim];
					r.evicted = 1'b1;
					r.evicted_key = cache_key[victim];
					cache_valid[victim] = 1'b0;
					cache_occ--;
					for (int i = 0; i < lfu_pkg::ENTRIES; i++)
						if (cache_valid[i] && cache_rank[i] > old_rank)
							cache_rank[i]--;
				end
			end
			slot = -1;
			for (int i = 0; i < lfu_pkg::ENTRIES; i++)
				if (slot < 0 && !cache_valid[i])
					slot = i;
			if (slot >= 0) begin
				for (int i = 0; i < lfu_pkg::ENTRIES; i++)
					if (cache_valid[i])
						cache_rank[i]++;
				cache_valid[slot] = 1'b1;
				cache_key[slot]   = k;
				cache_data[slot]  = v;
				cache_count[slot] = lfu_pkg::COUNT_ONE;
				cache_rank[slot]  = '0;
				cache_occ++;
			end
		end
		return r;
	endfunction

	task automatic report_bad(input string why, input reply_t want, input reply_t got);
		bad_beats++;
		if (bad_beats <= REPORT_MAX)
			$display("%0t %s: expected hit=%0b read=%h ev=%0b evkey=%h, %s",
				$realtime, why, want.hit, want.read_value, want.evicted, want.evicted_key,
				$sformatf("got hit=%0b read=%h ev=%0b evkey=%h",
					got.hit, got.read_value, got.evicted, got.evicted_key));
	endtask

	// one request beat; the prediction is taken at the accepting edge
	task automatic send_request(input logic is_put, input lfu_pkg::key_t k,
		input lfu_pkg::data_t v);
		int gap;
		if (send_gaps && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 19);
			@(negedge clk);
			req_ch.valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		req_ch.valid       = 1'b1;
		req_ch.req_type    = is_put;
		req_ch.lookup_key  = k;
		req_ch.write_value = v;
		do @(posedge clk); while (!req_ch.ready);
		replies_due.push_back(lfu_apply(is_put, k, v));
		requests_sent++;
	endtask

	task automatic wait_idle();
		@(negedge clk);
		req_ch.valid = 1'b0;
		while (replies_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_capacity(input logic [lfu_pkg::CFG_W-1:0] cap);
		wait_idle();
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_wdata = cap;
		cache_cap = cap;
		@(negedge clk);
		cfg_we = 1'b0;
		cap_writes++;
	endtask

	task automatic run_random(input int count, input logic [lfu_pkg::CFG_W-1:0] cap);
		int            eff;
		int            pool_size;
		lfu_pkg::key_t k;
		set_capacity(cap);
		eff = (cap > lfu_pkg::ENTRIES) ? lfu_pkg::ENTRIES : int'(cap);
		pool_size = eff + $urandom_range(1, 6);
		key_pool.delete();
		for (int j = 0; j < pool_size; j++) begin
			case ($urandom_range(0, 7))
				0:       key_pool.push_back(32'h8000_0000 + j);
				1:       key_pool.push_back(32'h7fff_ffff - j);
				2:       key_pool.push_back(lfu_pkg::key_t'(j));
				default: key_pool.push_back($urandom);
			endcase
		end
		for (int n = 0; n < count; n++) begin
			// skewed pick so some keys build up much higher counts than others
			if ($urandom_range(0, 99) < 85)
				k = key_pool[$urandom_range(0, $urandom_range(0, pool_size - 1))];
			else
				k = $urandom;
			send_request(1'($urandom_range(0, 1)), k, $urandom);
		end
	endtask

	// extremes of key and value, hits, misses and updates at the reset capacity
	task automatic test_basic_access();
		send_request(1'b0, 32'h0000_0000, 32'h0);
		send_request(1'b1, 32'h8000_0000, 32'h7fff_ffff);
		send_request(1'b1, 32'h7fff_ffff, 32'h8000_0000);
		send_request(1'b1, 32'hffff_ffff, 32'h0000_0000);
		send_request(1'b1, 32'h0000_0000, 32'hffff_ffff);
		send_request(1'b0, 32'h8000_0000, 32'h0);
		send_request(1'b0, 32'h7fff_ffff, 32'hffff_ffff);
		send_request(1'b0, 32'hffff_ffff, 32'h0);
		send_request(1'b1, 32'h0000_0000, 32'h1234_5678);
		send_request(1'b0, 32'h0000_0000, 32'h0);
		send_request(1'b0, 32'h0000_0001, 32'h0);
	endtask

	// capacity below occupancy, then lfu victims with lru among equal counts
	task automatic test_lfu_eviction();
		set_capacity(lfu_pkg::CFG_W'(2));
		send_request(1'b1, 32'd100, 32'ha5a5_a5a5);
		send_request(1'b1, 32'd101, 32'h5a5a_5a5a);
		send_request(1'b0, 32'd101, 32'h0);
		send_request(1'b1, 32'd102, 32'h0000_0102);
		send_request(1'b0, 32'd102, 32'h0);
		send_request(1'b0, 32'd102, 32'h0);
		send_request(1'b1, 32'd103, 32'h0000_0103);
		send_request(1'b1, 32'd104, 32'h0000_0104);
		send_request(1'b0, 32'h0000_0000, 32'h0);
	endtask

	// nothing new is stored, a present key still takes the update
	task automatic test_zero_capacity();
		set_capacity(lfu_pkg::CFG_W'(0));
		send_request(1'b1, 32'd200, 32'd5);
		send_request(1'b0, 32'd200, 32'h0);
		send_request(1'b1, 32'd104, 32'd77);
		send_request(1'b0, 32'd104, 32'h0);
	endtask

	task automatic test_random_capacities();
		logic [lfu_pkg::CFG_W-1:0] caps [8];
		caps = '{lfu_pkg::CFG_W'(16), lfu_pkg::CFG_W'(1), lfu_pkg::CFG_W'(31),
		         lfu_pkg::CFG_W'(5), lfu_pkg::CFG_W'(0), lfu_pkg::CFG_W'(17),
		         lfu_pkg::CFG_W'(2), lfu_pkg::CFG_W'(12)};
		send_gaps   = 1'b1;
		recv_stalls = 1'b1;
		foreach (caps[i])
			run_random(150, caps[i]);
	endtask

	// reply side held off long enough that the request side backs up
	task automatic test_input_backpressure();
		set_capacity(lfu_pkg::CFG_W'(3));
		send_gaps = 1'b0;
		@(posedge clk);
		hold_left = 300;
		for (int n = 0; n < 20; n++)
			send_request(1'($urandom_range(0, 1)), lfu_pkg::key_t'($urandom_range(0, 5)),
				$urandom);
		send_gaps = 1'b1;
		for (int n = 0; n < 20; n++)
			send_request(1'($urandom_range(0, 1)), lfu_pkg::key_t'($urandom_range(0, 5)),
				$urandom);
	endtask

	task automatic test_steady_stream();
		send_gaps   = 1'b0;
		recv_stalls = 1'b0;
		run_random(285, lfu_pkg::CFG_W'(16));
	endtask

	// reply sink with random stall bursts and an optional long hold
	initial begin : reply_sink
		int stall_left;
		stall_left   = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				rsp_ch.ready = 1'b0;
				hold_left--;
			end else if (stall_left > 0) begin
				rsp_ch.ready = 1'b0;
				stall_left--;
			end else begin
				rsp_ch.ready = 1'b1;
				if (recv_stalls && $urandom_range(0, 6) == 0)
					stall_left = $urandom_range(1, 19);
			end
		end
	end

	always @(posedge clk) begin : check_replies
		reply_t want;
		reply_t got;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got = '{hit: rsp_ch.hit, read_value: rsp_ch.read_value,
			        evicted: rsp_ch.evicted, evicted_key: rsp_ch.evicted_key};
			if (replies_due.size() == 0) begin
				want = '{hit: 1'b0, read_value: '0, evicted: 1'b0, evicted_key: '0};
				report_bad("reply beat with no request outstanding", want, got);
			end else begin
				want = replies_due.pop_front();
				if (got.hit !== want.hit || got.read_value !== want.read_value ||
				    got.evicted !== want.evicted || got.evicted_key !== want.evicted_key)
					report_bad("reply mismatch", want, got);
				if (got.hit === 1'b1)
					hits_seen++;
				if (got.evicted === 1'b1)
					evictions_seen++;
			end
		end
	end

	// ends the run when no beat moves on either channel for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("timeout: no beat for %0d cycles", STALL_LIMIT);
		$display("Mismatches found");
		$finish;
	end

	initial begin : main_sequence
		req_ch.valid       = 1'b0;
		req_ch.req_type    = 1'b0;
		req_ch.lookup_key  = '0;
		req_ch.write_value = '0;
		cfg_we      = 1'b0;
		cfg_wdata   = '0;
		arst_n      = 1'b0;
		bad_beats   = 0;
		requests_sent  = 0;
		hits_seen      = 0;
		evictions_seen = 0;
		cap_writes     = 0;
		hold_left      = 0;
		send_gaps      = 1'b0;
		recv_stalls    = 1'b0;
		cache_cap      = lfu_pkg::CAP_RESET;
		cache_occ      = 0;
		foreach (cache_valid[i])
			cache_valid[i] = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_basic_access();
		test_lfu_eviction();
		test_zero_capacity();
		test_random_capacities();
		test_input_backpressure();
		test_steady_stream();

		wait_idle();
		repeat (lfu_pkg::ENTRIES + 8) @(posedge clk);
		bad_beats += replies_due.size();
		$display("covered %0d requests with %0d hits and %0d evictions over %0d capacity writes",
			requests_sent, hits_seen, evictions_seen, cap_writes);
		if (bad_beats == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
